// File: rtl/rcg_pkg.sv
package rcg_pkg;

  // channel width and the widths that follow from it
  localparam int unsigned CHANNEL_BITS = 16;
  localparam int unsigned NUM_STAGES   = 7;

  localparam int unsigned CW  = CHANNEL_BITS + 4;   // gained channel, luma
  localparam int unsigned SQW = CHANNEL_BITS + 8;   // squared weights
  localparam int unsigned AMW = CHANNEL_BITS + 13;  // tint amount
  localparam int unsigned ADW = CHANNEL_BITS + 11;  // per-channel tint term
  localparam int unsigned CHW = CHANNEL_BITS + 13;  // tinted channel
  localparam int unsigned TQW = 21;                 // tint times strength, signed q9.12
  localparam int unsigned TW  = CHANNEL_BITS + 8;   // theme offset, channel scale
  localparam int unsigned VW  = CHANNEL_BITS + 21;  // blended channel

  localparam int unsigned T_UP = (CHANNEL_BITS >= 12) ? CHANNEL_BITS - 12 : 0;
  localparam int unsigned T_DN = (CHANNEL_BITS >= 12) ? 0 : 12 - CHANNEL_BITS;

  // q0.16 constants
  localparam int unsigned W_RED       = 19595;
  localparam int unsigned W_GREEN     = 38470;
  localparam int unsigned W_BLUE      = 7471;
  localparam int unsigned K_TENTH     = 6554;
  localparam int unsigned K_TWENTIETH = 3277;
  localparam int unsigned K_FIFTIETH  = 1311;

  // register file
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  typedef enum logic [2:0] {
    REG_GAIN_RED    = 3'd0,
    REG_GAIN_GREEN  = 3'd1,
    REG_GAIN_BLUE   = 3'd2,
    REG_SHADOW_WARM = 3'd3,
    REG_HILITE_COOL = 3'd4,
    REG_VIBRANCY    = 3'd5,
    REG_STRENGTH    = 3'd6,
    REG_THEME_TINT  = 3'd7
  } reg_idx_e;

  localparam logic [15:0] GAIN_RESET = 16'd4096;
  localparam logic [15:0] VIB_RESET  = 16'd4096;

  typedef struct packed {
    logic [15:0] filter_gain_red;
    logic [15:0] filter_gain_green;
    logic [15:0] filter_gain_blue;
    logic [15:0] shadow_warmth;
    logic [15:0] highlight_cool;
    logic [15:0] vibrancy;
    logic [15:0] style_strength;
    logic [47:0] theme_tint;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    filter_gain_red:   GAIN_RESET,
    filter_gain_green: GAIN_RESET,
    filter_gain_blue:  GAIN_RESET,
    shadow_warmth:     16'h0000,
    highlight_cool:    16'h0000,
    vibrancy:          VIB_RESET,
    style_strength:    16'h0000,
    theme_tint:        48'h0
  };

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
  } pix_out_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;   // stage may load this cycle
    logic [NUM_STAGES-1:0] vld;  // stage holds a request
  } pipe_ctrl_t;

endpackage

// File: rtl/rcg_regs.sv
module rcg_regs
  import rcg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_GAIN_RED:    cfg_d.filter_gain_red   = pwdata[15:0];
        REG_GAIN_GREEN:  cfg_d.filter_gain_green = pwdata[15:0];
        REG_GAIN_BLUE:   cfg_d.filter_gain_blue  = pwdata[15:0];
        REG_SHADOW_WARM: cfg_d.shadow_warmth     = pwdata[15:0];
        REG_HILITE_COOL: cfg_d.highlight_cool    = pwdata[15:0];
        REG_VIBRANCY:    cfg_d.vibrancy          = pwdata[15:0];
        REG_STRENGTH:    cfg_d.style_strength    = pwdata[15:0];
        REG_THEME_TINT:  cfg_d.theme_tint        = pwdata[47:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_RED:    prdata = DATA_W'(cfg_q.filter_gain_red);
      REG_GAIN_GREEN:  prdata = DATA_W'(cfg_q.filter_gain_green);
      REG_GAIN_BLUE:   prdata = DATA_W'(cfg_q.filter_gain_blue);
      REG_SHADOW_WARM: prdata = DATA_W'(cfg_q.shadow_warmth);
      REG_HILITE_COOL: prdata = DATA_W'(cfg_q.highlight_cool);
      REG_VIBRANCY:    prdata = DATA_W'(cfg_q.vibrancy);
      REG_STRENGTH:    prdata = DATA_W'(cfg_q.style_strength);
      REG_THEME_TINT:  prdata = DATA_W'(cfg_q.theme_tint);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/rcg_ctrl.sv
module rcg_ctrl
  import rcg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pipe_ctrl_t ctl_o
);

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] en;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign ctl_o.en    = en;
  assign ctl_o.vld   = vld_q;

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NUM_STAGES-1] |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request missing from first stage");

  a_stalled_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !en[2] |=> vld_q[2] && vld_q[NUM_STAGES-1])
    else $error("stalled stage lost its request");

endmodule

// File: rtl/rcg_datapath.sv
module rcg_datapath
  import rcg_pkg::*;
(
  input  logic       clk_i,
  input  cfg_t       cfg_i,
  input  pipe_ctrl_t ctl_i,
  input  pix_in_t    in_data_i,
  output pix_out_t   out_data_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam logic [CB+5:0] ONE = (CB+6)'(1) << CB;
  localparam logic [CB-1:0] TOP = '1;

  logic [NUM_STAGES-1:0] ld;
  assign ld = ctl_i.en & {ctl_i.vld[NUM_STAGES-2:0], 1'b1};

  logic [CB-1:0] pin  [3];
  logic [15:0]   gain [3];
  logic [15:0]   tint [3];

  assign pin[0]  = in_data_i.in_red;
  assign pin[1]  = in_data_i.in_green;
  assign pin[2]  = in_data_i.in_blue;
  assign gain[0] = cfg_i.filter_gain_red;
  assign gain[1] = cfg_i.filter_gain_green;
  assign gain[2] = cfg_i.filter_gain_blue;
  assign tint[0] = cfg_i.theme_tint[15:0];
  assign tint[1] = cfg_i.theme_tint[31:16];
  assign tint[2] = cfg_i.theme_tint[47:32];

  // stage 1: filter gain, tint times strength
  logic [CB+15:0]         gprod [3];
  logic signed [32:0]     tprod [3];
  logic [CW-1:0]          c1_d [3], c1_q [3];
  logic signed [TQW-1:0]  t1_d [3], t1_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gprod[i] = (CB+16)'(pin[i]) * (CB+16)'(gain[i]);
      tprod[i] = $signed({{17{tint[i][15]}}, tint[i]}) * $signed({17'b0, cfg_i.style_strength});
      c1_d[i]  = gprod[i][CB+15:12];
      t1_d[i]  = $signed(tprod[i][32:12]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      c1_q <= c1_d;
      t1_q <= t1_d;
    end
  end

  // stage 2: luma, theme offset at channel scale
  logic [CB+19:0]        lsum;
  logic [CW-1:0]         luma2_d, luma2_q;
  logic [CW-1:0]         c2_q [3];
  logic signed [35:0]    tk [3];
  logic signed [31:0]    tw [3];
  logic signed [31:0]    tch [3];
  logic signed [TW-1:0]  t2_d [3], t2_q [3];

  always_comb begin
    lsum = (CB+20)'(c1_q[0]) * (CB+20)'(W_RED)
         + (CB+20)'(c1_q[1]) * (CB+20)'(W_GREEN)
         + (CB+20)'(c1_q[2]) * (CB+20)'(W_BLUE);
    luma2_d = lsum[CB+19:16];
    for (int i = 0; i < 3; i++) begin
      tk[i]   = 36'(t1_q[i]) * $signed(36'(K_TENTH));
      tw[i]   = 32'($signed(tk[i][35:16]));
      tch[i]  = (CB >= 12) ? (tw[i] <<< T_UP) : (tw[i] >>> T_DN);
      t2_d[i] = $signed(tch[i][TW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      luma2_q <= luma2_d;
      c2_q    <= c1_q;
      t2_q    <= t2_d;
    end
  end

  // stage 3: squared shadow and highlight weights
  logic signed [CB+5:0]    sf;
  logic signed [2*CB+11:0] sfsq;
  logic [2*CB+7:0]         lsq;
  logic [SQW-1:0]          sqs3_d, sqs3_q, sqh3_d, sqh3_q;
  logic [CW-1:0]           luma3_q;
  logic [CW-1:0]           c3_q [3];
  logic signed [TW-1:0]    t3_q [3];

  always_comb begin
    sf     = $signed(ONE) - $signed({2'b0, luma2_q});
    sfsq   = sf * sf;
    lsq    = (2*CB+8)'(luma2_q) * (2*CB+8)'(luma2_q);
    sqs3_d = sfsq[2*CB+7:CB];
    sqh3_d = lsq[2*CB+7:CB];
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      sqs3_q  <= sqs3_d;
      sqh3_q  <= sqh3_d;
      luma3_q <= luma2_q;
      c3_q    <= c2_q;
      t3_q    <= t2_q;
    end
  end

  // stage 4: tint amounts
  logic signed [CB+24:0]  aprod_s, aprod_h;
  logic signed [AMW-1:0]  ams4_d, ams4_q, amh4_d, amh4_q;
  logic [CW-1:0]          luma4_q;
  logic [CW-1:0]          c4_q [3];
  logic signed [TW-1:0]   t4_q [3];

  always_comb begin
    aprod_s = $signed({1'b0, sqs3_q}) * $signed(cfg_i.shadow_warmth);
    aprod_h = $signed({1'b0, sqh3_q}) * $signed(cfg_i.highlight_cool);
    ams4_d  = $signed(aprod_s[CB+24:12]);
    amh4_d  = $signed(aprod_h[CB+24:12]);
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      ams4_q  <= ams4_d;
      amh4_q  <= amh4_d;
      luma4_q <= luma3_q;
      c4_q    <= c3_q;
      t4_q    <= t3_q;
    end
  end

  // stage 5: add shadow and highlight tints
  logic signed [CB+26:0]  p_sr, p_sg, p_hb, p_hg;
  logic signed [ADW-1:0]  a_sr, a_sg, a_hb, a_hg;
  logic signed [CHW-1:0]  ch5_d [3], ch5_q [3];
  logic [CW-1:0]          luma5_q;
  logic signed [TW-1:0]   t5_q [3];

  always_comb begin
    p_sr = ams4_q * $signed(14'(K_TENTH));
    p_sg = ams4_q * $signed(14'(K_TWENTIETH));
    p_hb = amh4_q * $signed(14'(K_TENTH));
    p_hg = amh4_q * $signed(14'(K_FIFTIETH));
    a_sr = $signed(p_sr[CB+26:16]);
    a_sg = $signed(p_sg[CB+26:16]);
    a_hb = $signed(p_hb[CB+26:16]);
    a_hg = $signed(p_hg[CB+26:16]);
    ch5_d[0] = CHW'($signed({1'b0, c4_q[0]})) + CHW'(a_sr);
    ch5_d[1] = CHW'($signed({1'b0, c4_q[1]})) + CHW'(a_sg) + CHW'(a_hg);
    ch5_d[2] = CHW'($signed({1'b0, c4_q[2]})) + CHW'(a_hb);
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      ch5_q   <= ch5_d;
      luma5_q <= luma4_q;
      t5_q    <= t4_q;
    end
  end

  // stage 6: vibrancy blend about luma, theme offset
  logic signed [CB+13:0] diff [3];
  logic signed [CB+30:0] vprod [3];
  logic signed [VW-1:0]  v6_d [3], v6_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = (CB+14)'(ch5_q[i]) - (CB+14)'($signed({1'b0, luma5_q}));
      vprod[i] = diff[i] * $signed({1'b0, cfg_i.vibrancy});
      v6_d[i]  = VW'($signed(vprod[i][CB+30:12])) + VW'($signed({1'b0, luma5_q}))
               + VW'(t5_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      v6_q <= v6_d;
    end
  end

  // stage 7: clamp into the output register
  logic [CB-1:0] cl [3];
  pix_out_t      out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (v6_q[i] < 0) begin
        cl[i] = '0;
      end else if (v6_q[i] > VW'($signed({1'b0, TOP}))) begin
        cl[i] = TOP;
      end else begin
        cl[i] = v6_q[i][CB-1:0];
      end
    end
    out_d.out_red   = cl[0];
    out_d.out_green = cl[1];
    out_d.out_blue  = cl[2];
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/rgb_color_grading.sv
// Colour grading for a pixel stream: each RGB pixel is scaled by per-channel
// filter gains, tinted warm in the shadows and cool in the highlights by
// weights from its Rec.601 luma, blended about that luma by the vibrancy
// factor, offset by the theme tint and clamped to full scale. The block takes
// one pixel per clock and passes it through each register stage of the
// seven-stage datapath (gain, luma, squares, tint amounts, tint add, blend,
// clamp); ready drops only when the output is stalled and every stage is
// full. Registers are written over the APB port at byte address 8*i and
// should be changed only while no pixel is in flight.
module rgb_color_grading
  import rcg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pix_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pix_out_t          out_data_o
);

  cfg_t       cfg;
  pipe_ctrl_t ctl;

  rcg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  rcg_datapath u_datapath (
    .clk_i      (clk_i),
    .cfg_i      (cfg),
    .ctl_i      (ctl),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: test/grading_checker.sv
module grading_checker
  import rcg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pix_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pix_out_t          out_data_i,
  output int                err_count_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LUMA_R    = 19595;
  localparam longint LUMA_G    = 38470;
  localparam longint LUMA_B    = 7471;
  localparam longint TENTH     = 6554;
  localparam longint TWENTIETH = 3277;
  localparam longint FIFTIETH  = 1311;
  localparam longint ONE       = longint'(1) << CHANNEL_BITS;
  localparam longint TOP       = ONE - 1;

  cfg_t     grading_cfg;
  pix_out_t graded_q[$];

  function automatic pix_out_t grade_pixel(pix_in_t px, cfg_t c);
    longint                  chan[3];
    longint                  luma, sf, sq, amt, warm, cool, vib, strength, tint, t;
    logic [CHANNEL_BITS-1:0] q[3];
    pix_out_t                res;
    chan[0] = (longint'(px.in_red)   * longint'(c.filter_gain_red))   >>> 12;
    chan[1] = (longint'(px.in_green) * longint'(c.filter_gain_green)) >>> 12;
    chan[2] = (longint'(px.in_blue)  * longint'(c.filter_gain_blue))  >>> 12;
    warm     = longint'($signed(c.shadow_warmth));
    cool     = longint'($signed(c.highlight_cool));
    vib      = longint'(c.vibrancy);
    strength = longint'(c.style_strength);

    luma = (chan[0] * LUMA_R + chan[1] * LUMA_G + chan[2] * LUMA_B) >>> 16;

    // warm tint in the shadows, weighted by (1 - luma) squared
    sf  = ONE - luma;
    sq  = (sf * sf) >>> CHANNEL_BITS;
    amt = (sq * warm) >>> 12;
    chan[0] += (amt * TENTH) >>> 16;
    chan[1] += (amt * TWENTIETH) >>> 16;

    // cool tint in the highlights, weighted by luma squared
    sq  = (luma * luma) >>> CHANNEL_BITS;
    amt = (sq * cool) >>> 12;
    chan[2] += (amt * TENTH) >>> 16;
    chan[1] += (amt * FIFTIETH) >>> 16;

    for (int i = 0; i < 3; i++) begin
      tint    = longint'($signed(c.theme_tint[16*i +: 16]));
      t       = (((tint * strength) >>> 12) * TENTH) >>> 16;
      chan[i] = luma + (((chan[i] - luma) * vib) >>> 12);
      if (CHANNEL_BITS >= 12) begin
        chan[i] += t <<< (CHANNEL_BITS - 12);
      end else begin
        chan[i] += t >>> (12 - CHANNEL_BITS);
      end
      if (chan[i] < 0) begin
        q[i] = '0;
      end else if (chan[i] > TOP) begin
        q[i] = '1;
      end else begin
        q[i] = chan[i][CHANNEL_BITS-1:0];
      end
    end
    res.out_red   = q[0];
    res.out_green = q[1];
    res.out_blue  = q[2];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] error: %s", $realtime, msg);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      grading_cfg = CFG_RESET;
      graded_q.delete();
      err_count_o = 0;
      checked_o   = 0;
      pending_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        graded_q.push_back(grade_pixel(in_data_i, grading_cfg));
      end

      if (out_valid_i && out_ready_i) begin
        if (graded_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding", out_data_i));
        end else begin
          want = graded_q.pop_front();
          if (out_data_i.out_red !== want.out_red)
            report_mismatch($sformatf("pixel %0d red: got %h expected %h",
                                      checked_o, out_data_i.out_red, want.out_red));
          if (out_data_i.out_green !== want.out_green)
            report_mismatch($sformatf("pixel %0d green: got %h expected %h",
                                      checked_o, out_data_i.out_green, want.out_green));
          if (out_data_i.out_blue !== want.out_blue)
            report_mismatch($sformatf("pixel %0d blue: got %h expected %h",
                                      checked_o, out_data_i.out_blue, want.out_blue));
          checked_o++;
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:3]))
          REG_GAIN_RED:    grading_cfg.filter_gain_red   = pwdata[15:0];
          REG_GAIN_GREEN:  grading_cfg.filter_gain_green = pwdata[15:0];
          REG_GAIN_BLUE:   grading_cfg.filter_gain_blue  = pwdata[15:0];
          REG_SHADOW_WARM: grading_cfg.shadow_warmth     = pwdata[15:0];
          REG_HILITE_COOL: grading_cfg.highlight_cool    = pwdata[15:0];
          REG_VIBRANCY:    grading_cfg.vibrancy          = pwdata[15:0];
          REG_STRENGTH:    grading_cfg.style_strength    = pwdata[15:0];
          REG_THEME_TINT:  grading_cfg.theme_tint        = pwdata[47:0];
          default: ;
        endcase
      end

      pending_o = graded_q.size();
    end
  end

endmodule

// File: test/tb.sv
module tb;
  import rcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 12;
  localparam int RAND_PHASES  = 6;
  localparam int RAND_PER_SET = 65;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  pix_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  pix_out_t          out_data;

  int      err_count;
  int      pending;
  int      checked;
  int      settings_used;
  int      idle_cycles;
  bit      steady;
  bit      hold_req;
  pix_in_t pixel_q[$];

  rgb_color_grading uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  grading_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_field(logic [15:0] nominal);
    case ($urandom_range(0, 5))
      0: return nominal;
      1: return nominal + 16'($urandom_range(0, 1023)) - 16'd512;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHANNEL_BITS'($urandom);
    endcase
  endfunction

  function automatic pix_in_t make_pixel(logic [CHANNEL_BITS-1:0] r,
                                         logic [CHANNEL_BITS-1:0] g,
                                         logic [CHANNEL_BITS-1:0] b);
    pix_in_t p;
    p.in_red   = r;
    p.in_green = g;
    p.in_blue  = b;
    return p;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(int'(idx) * 8);
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_setting(cfg_t c);
    write_reg(REG_GAIN_RED,    DATA_W'(c.filter_gain_red));
    write_reg(REG_GAIN_GREEN,  DATA_W'(c.filter_gain_green));
    write_reg(REG_GAIN_BLUE,   DATA_W'(c.filter_gain_blue));
    write_reg(REG_SHADOW_WARM, DATA_W'(c.shadow_warmth));
    write_reg(REG_HILITE_COOL, DATA_W'(c.highlight_cool));
    write_reg(REG_VIBRANCY,    DATA_W'(c.vibrancy));
    write_reg(REG_STRENGTH,    DATA_W'(c.style_strength));
    write_reg(REG_THEME_TINT,  DATA_W'(c.theme_tint));
    settings_used++;
  endtask

  // valid stays up across back-to-back requests, only the data moves
  task automatic send_pixels();
    pix_in_t p;
    int      gap;
    while (pixel_q.size() != 0) begin
      p   = pixel_q.pop_front();
      gap = pick_gap();
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid = 1'b1;
      in_data  = p;
      do @(posedge clk_i); while (!in_ready);
      @(negedge clk_i);
    end
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_directed();
    pixel_q.push_back(make_pixel('0, '0, '0));
    pixel_q.push_back(make_pixel('1, '1, '1));
    pixel_q.push_back(make_pixel('1, '0, '0));
    pixel_q.push_back(make_pixel('0, '1, '0));
    pixel_q.push_back(make_pixel('0, '0, '1));
    pixel_q.push_back(make_pixel(16'h8000, 16'h8000, 16'h8000));
    pixel_q.push_back(make_pixel(16'h5555, 16'haaaa, 16'h5555));
    pixel_q.push_back(make_pixel(16'haaaa, 16'h5555, 16'haaaa));
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      n = pick_gap();
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    cfg_t setting;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    settings_used = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values first
    queue_directed();
    send_pixels();
    drain();

    // every gain, vibrancy and strength at its top end, tints at their signed extremes, full saturation
    setting = '{
      filter_gain_red:   16'hffff,
      filter_gain_green: 16'hffff,
      filter_gain_blue:  16'hffff,
      shadow_warmth:     16'h7fff,
      highlight_cool:    16'h8000,
      vibrancy:          16'hffff,
      style_strength:    16'hffff,
      theme_tint:        {16'h7fff, 16'h8000, 16'h7fff}
    };
    load_setting(setting);
    queue_directed();
    send_pixels();
    drain();

    // zero gains and vibrancy, opposite tint signs
    setting = '{
      filter_gain_red:   16'h0000,
      filter_gain_green: 16'h0000,
      filter_gain_blue:  16'h0000,
      shadow_warmth:     16'h8000,
      highlight_cool:    16'h7fff,
      vibrancy:          16'h0000,
      style_strength:    16'hffff,
      theme_tint:        {16'h8000, 16'h7fff, 16'h8000}
    };
    load_setting(setting);
    queue_directed();
    send_pixels();
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      setting.filter_gain_red   = rand_field(GAIN_RESET);
      setting.filter_gain_green = rand_field(GAIN_RESET);
      setting.filter_gain_blue  = rand_field(GAIN_RESET);
      setting.shadow_warmth     = rand_field(16'h1000);
      setting.highlight_cool    = rand_field(16'h1000);
      setting.vibrancy          = rand_field(VIB_RESET);
      setting.style_strength    = rand_field(16'h1000);
      setting.theme_tint        = {rand_field(16'h0800), rand_field(16'h0800),
                                   rand_field(16'h0800)};
      load_setting(setting);
      steady   = (ph == 2) || (ph == 3);
      hold_req = (ph == 3);
      for (int k = 0; k < RAND_PER_SET; k++) begin
        pixel_q.push_back(make_pixel(rand_channel(), rand_channel(), rand_channel()));
      end
      send_pixels();
      drain();
      steady = 1'b0;
    end

    $display("summary: %0d graded pixels compared over %0d register settings,", checked,
             settings_used);
    $display("including saturating extremes and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
